[rtl/core/cdc_pkg.sv]
// Shared types, constants and the gear hash table for the content-defined chunker.
package cdc_pkg;

  localparam int OFFSET_BITS = 48;
  localparam int LENGTH_BITS = 31;
  localparam int HASH_BITS   = 64;
  localparam int DATA_BITS   = 64;
  localparam int ADDR_BITS   = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] GEAR_SEED  = 64'h5354_4D43_4443_7632;
  localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

  localparam logic [LENGTH_BITS-1:0] MIN_CHUNK_RESET = LENGTH_BITS'(2097152);
  localparam logic [LENGTH_BITS-1:0] AVG_CHUNK_RESET = LENGTH_BITS'(8388608);
  localparam logic [LENGTH_BITS-1:0] MAX_CHUNK_RESET = LENGTH_BITS'(33554432);

  typedef enum logic [1:0] {
    CAUSE_HASH = 2'd0,
    CAUSE_MAX  = 2'd1,
    CAUSE_END  = 2'd2
  } cut_cause_t;

  typedef enum logic [2:0] {
    REG_MIN_CHUNK   = 3'd0,
    REG_AVG_CHUNK   = 3'd1,
    REG_MAX_CHUNK   = 3'd2,
    REG_STRICT_MASK = 3'd3,
    REG_LOOSE_MASK  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] min_chunk;
    logic [LENGTH_BITS-1:0] avg_chunk;
    logic [LENGTH_BITS-1:0] max_chunk;
    logic [HASH_BITS-1:0]   strict_mask;
    logic [HASH_BITS-1:0]   loose_mask;
  } cfg_t;

  // One queued byte: its gear value is fetched up front.
  typedef struct packed {
    logic [HASH_BITS-1:0] gear;
    logic                 last;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef logic [255:0][HASH_BITS-1:0] gear_table_t;

  // Evaluated at elaboration only; it fills the constant table below.
  function automatic gear_table_t gear_table();
    gear_table_t t;
    logic [63:0] seed;
    logic [63:0] z;
    seed = GEAR_SEED;
    for (int k = 0; k < 256; k++) begin
      seed = seed + MIX_GOLDEN;
      z = seed;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      t[k] = z ^ (z >> 31);
    end
    return t;
  endfunction

  localparam gear_table_t GEAR_ROM = gear_table();

endpackage

[rtl/core/cdc_front.sv]
// Front end: accepts stream bytes, looks up their gear values and pushes them to the queue.
module cdc_front import cdc_pkg::*; (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          stream_end,
  input  queue_status_t qstat,
  output logic          push,
  output queue_entry_t  push_entry
);

  assign in_stall        = qstat.full;
  assign push            = in_valid && !qstat.full;
  assign push_entry.gear = GEAR_ROM[data_byte];
  assign push_entry.last = stream_end;

endmodule

[rtl/core/cdc_queue.sv]
// Short queue that decouples the byte front end from the hashing back end.
module cdc_queue import cdc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  queue_entry_t  push_entry,
  input  logic          pop,
  output queue_entry_t  head,
  output queue_status_t qstat
);

  queue_entry_t         slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/cdc_back.sv]
// Back end: rolling gear hash, chunk and stream positions, cut decision and result register.
module cdc_back import cdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  queue_entry_t           head,
  input  queue_status_t          qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OFFSET_BITS-1:0] end_offset,
  output logic [LENGTH_BITS-1:0] chunk_length,
  output logic [1:0]             cut_cause
);

  logic [HASH_BITS-1:0]   rolling_hash;
  logic [LENGTH_BITS-1:0] chunk_position;
  logic [OFFSET_BITS-1:0] stream_position;

  logic [LENGTH_BITS:0]   len;
  logic [HASH_BITS-1:0]   hash_next;
  logic [HASH_BITS-1:0]   mask;
  logic [OFFSET_BITS-1:0] offset_next;
  logic                   in_window;
  logic                   match;
  logic                   forced;
  logic                   cut;
  cut_cause_t             cause;

  assign pop = !qstat.empty && (!out_valid || !out_stall);

  always_comb begin
    len         = {1'b0, chunk_position} + 1'b1;
    offset_next = stream_position + 1'b1;
    in_window   = (chunk_position >= cfg.min_chunk) && (chunk_position < cfg.max_chunk);
    mask        = (chunk_position < cfg.avg_chunk) ? cfg.strict_mask : cfg.loose_mask;
    hash_next   = {rolling_hash[HASH_BITS-2:0], 1'b0} + head.gear;
    match       = in_window && ((hash_next & mask) == '0);
    // A forced cut needs the length to reach both the maximum and the minimum.
    forced      = (len >= {1'b0, cfg.max_chunk}) && (len >= {1'b0, cfg.min_chunk});
    cut         = match || forced || head.last;
    priority if (match) begin
      cause = CAUSE_HASH;
    end else if (forced) begin
      cause = CAUSE_MAX;
    end else begin
      cause = CAUSE_END;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cut) begin
      end_offset   <= offset_next;
      chunk_length <= len[LENGTH_BITS-1:0];
      cut_cause    <= cause;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_hash    <= '0;
      chunk_position  <= '0;
      stream_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        stream_position <= head.last ? '0 : offset_next;
        if (cut) begin
          rolling_hash   <= '0;
          chunk_position <= '0;
          out_valid      <= 1'b1;
        end else begin
          if (in_window) begin
            rolling_hash <= hash_next;
          end
          chunk_position <= len[LENGTH_BITS-1:0];
          out_valid      <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/content_defined_chunker.sv]
// Top level of the content-defined chunker: register file, front end, queue and back end.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_stall    data_byte, stream_end
//   out       output     out_valid/out_stall  end_offset, chunk_length, cut_cause
//   cfg       input      APB psel/penable     paddr, pwdata, prdata (64-bit, 8-byte stride)
//
// One byte per cycle is sustained unless a held result is stalled by out_stall.
// A cut byte passes through a queue slot and then the result register before out_valid.
// The two-entry queue lets the input keep flowing until it fills while the output is stalled.
// Synchronous reset clears positions, hash, queue and config registers to their defaults.
module content_defined_chunker import cdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   stream_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OFFSET_BITS-1:0] end_offset,
  output logic [LENGTH_BITS-1:0] chunk_length,
  output logic [1:0]             cut_cause,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]   prdata,
  output logic                   pready
);

  cfg_t          cfg;
  queue_status_t qstat;
  queue_entry_t  push_entry;
  queue_entry_t  head;
  logic          push;
  logic          pop;
  logic          wr_en;
  reg_index_t    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_t'(paddr[ADDR_BITS-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_chunk   <= MIN_CHUNK_RESET;
      cfg.avg_chunk   <= AVG_CHUNK_RESET;
      cfg.max_chunk   <= MAX_CHUNK_RESET;
      cfg.strict_mask <= '0;
      cfg.loose_mask  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MIN_CHUNK:   cfg.min_chunk   <= pwdata[LENGTH_BITS-1:0];
        REG_AVG_CHUNK:   cfg.avg_chunk   <= pwdata[LENGTH_BITS-1:0];
        REG_MAX_CHUNK:   cfg.max_chunk   <= pwdata[LENGTH_BITS-1:0];
        REG_STRICT_MASK: cfg.strict_mask <= pwdata;
        REG_LOOSE_MASK:  cfg.loose_mask  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_CHUNK:   prdata = DATA_BITS'(cfg.min_chunk);
      REG_AVG_CHUNK:   prdata = DATA_BITS'(cfg.avg_chunk);
      REG_MAX_CHUNK:   prdata = DATA_BITS'(cfg.max_chunk);
      REG_STRICT_MASK: prdata = cfg.strict_mask;
      REG_LOOSE_MASK:  prdata = cfg.loose_mask;
      default:         prdata = '0;
    endcase
  end

  cdc_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  cdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  cdc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .end_offset   (end_offset),
    .chunk_length (chunk_length),
    .cut_cause    (cut_cause)
  );

endmodule
